FILE: hdl/tas_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tas_pkg: shared types and constants for the two-axis position servo
// Holds the register map codes, configuration groups and fixed scaling
// constants used by the axis datapath and the top level.
// ---------------------------------------------------------------------------
package tas_pkg;

    // Configuration register map
    typedef enum logic [2:0] {
        CFG_LEFT_LOW   = 3'd0,
        CFG_LEFT_HIGH  = 3'd1,
        CFG_RIGHT_LOW  = 3'd2,
        CFG_RIGHT_HIGH = 3'd3,
        CFG_NULL_BAND  = 3'd4,
        CFG_GAIN       = 3'd5,
        CFG_FRICTION   = 3'd6,
        CFG_POWER_CAP  = 3'd7
    } t_cfg_idx;

    localparam int POS_W = 11;

    // Per-axis travel window and friction offset
    typedef struct packed {
        logic signed [POS_W-1:0] low_bound;
        logic signed [POS_W-1:0] high_bound;
        logic        [7:0]       friction;
    } t_axis_cfg;

    // Settings shared by both axes
    typedef struct packed {
        logic [7:0] null_band;
        logic [7:0] gain;
        logic [6:0] power_cap;
    } t_loop_cfg;

    // Per-axis control bits that travel with a beat
    typedef struct packed {
        logic enable;
        logic low_stop;
        logic high_stop;
    } t_axis_ctl;

    // Reset values of the registers
    localparam logic signed [POS_W-1:0] RST_LOW_BOUND  = -11'sd400;
    localparam logic signed [POS_W-1:0] RST_HIGH_BOUND = 11'sd400;
    localparam logic [7:0]  RST_NULL_BAND = 8'd5;
    localparam logic [7:0]  RST_GAIN      = 8'd10;
    localparam logic [15:0] RST_FRICTION  = 16'd0;
    localparam logic [6:0]  RST_POWER_CAP = 7'd100;

    // Full-scale drive in percent
    localparam logic [6:0] POWER_FULL = 7'd100;

    // Divide by 10 as multiply by ceil(2^23/10), exact for values below 2^22
    localparam logic [19:0] RECIP_10 = 20'd838861;
    localparam int          SHIFT_10 = 23;

    // Divide by 100 as multiply by ceil(2^20/100), exact for values below 2^15
    localparam logic [13:0] RECIP_100 = 14'd10486;
    localparam int          SHIFT_100 = 20;

endpackage
`default_nettype wire

FILE: hdl/tas_axis.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tas_axis: one axis of the proportional servo
// Three register stages: error and gain product, scaled and limited power
// magnitude, then signed power and servo pulse.
// ---------------------------------------------------------------------------
module tas_axis #(
    parameter int PULSE_ZERO = 90,
    parameter int PULSE_SPAN = 90
) (
    input  wire logic                  i_clk,
    input  wire tas_pkg::t_axis_cfg    i_axis_cfg,
    input  wire tas_pkg::t_loop_cfg    i_loop_cfg,
    input  wire tas_pkg::t_axis_ctl    i_ctl,
    input  wire logic signed [10:0]    i_target,
    input  wire logic signed [10:0]    i_position,
    output logic signed [7:0]          o_power,
    output logic [7:0]                 o_pulse
);
    import tas_pkg::*;

    localparam logic [7:0] ZERO = PULSE_ZERO[7:0];
    localparam logic [6:0] SPAN = PULSE_SPAN[6:0];

    // Stage A: clamp target, error, dead band test and gain product
    logic signed [POS_W-1:0] s_tgt;
    logic signed [POS_W:0]   s_err;
    logic [POS_W:0]          s_err_abs;
    logic [POS_W-1:0]        s_mag;
    logic                    n_act;
    logic [18:0]             n_prod;

    always_comb begin
        s_tgt = i_target;
        if (s_tgt > i_axis_cfg.high_bound) begin
            s_tgt = i_axis_cfg.high_bound;
        end
        if (s_tgt < i_axis_cfg.low_bound) begin
            s_tgt = i_axis_cfg.low_bound;
        end
        s_err     = {s_tgt[POS_W-1], s_tgt} - {i_position[POS_W-1], i_position};
        s_err_abs = s_err[POS_W] ? (-s_err) : s_err;
        s_mag     = s_err_abs[POS_W-1:0];
        n_act     = i_ctl.enable && (s_mag > {3'b000, i_loop_cfg.null_band});
        n_prod    = 19'(s_mag) * 19'(i_loop_cfg.gain);
    end

    logic [18:0] r_prod;
    logic        r_neg_a;
    logic        r_act;
    t_axis_ctl   r_ctl_a;

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_neg_a <= s_err[POS_W];
        r_act   <= n_act;
        r_ctl_a <= i_ctl;
    end

    // Stage B: divide by ten, friction offset, limits and stop gating
    logic [38:0] s_scaled;
    logic [15:0] s_quot;
    logic [16:0] s_sum;
    logic [6:0]  s_lim;
    logic [6:0]  n_pmag;

    always_comb begin
        s_scaled = 39'(r_prod) * 39'(RECIP_10);
        s_quot   = s_scaled[SHIFT_10 +: 16];
        s_sum    = 17'(s_quot) + 17'(i_axis_cfg.friction);
        s_lim    = (i_loop_cfg.power_cap > POWER_FULL) ? POWER_FULL : i_loop_cfg.power_cap;
        if (!r_act || (s_quot == 16'd0)) begin
            n_pmag = 7'd0;
        end else if (s_sum > 17'(s_lim)) begin
            n_pmag = s_lim;
        end else begin
            n_pmag = s_sum[6:0];
        end
        // An end switch blocks only drive toward it
        if ((!r_neg_a && r_ctl_a.high_stop) || (r_neg_a && r_ctl_a.low_stop)) begin
            n_pmag = 7'd0;
        end
    end

    logic [6:0] r_pmag;
    logic       r_neg_b;

    always_ff @(posedge i_clk) begin
        r_pmag  <= n_pmag;
        r_neg_b <= r_neg_a;
    end

    // Stage C: signed power and servo pulse, scaled with truncation to zero
    logic [13:0]       s_span_prod;
    logic [27:0]       s_pulse_scaled;
    logic [7:0]        s_pulse_mag;
    logic signed [7:0] n_power;
    logic [7:0]        n_pulse;

    always_comb begin
        s_span_prod    = 14'(r_pmag) * 14'(SPAN);
        s_pulse_scaled = 28'(s_span_prod) * 28'(RECIP_100);
        s_pulse_mag    = {1'b0, s_pulse_scaled[SHIFT_100 +: 7]};
        n_power        = r_neg_b ? (-$signed({1'b0, r_pmag})) : $signed({1'b0, r_pmag});
        n_pulse        = r_neg_b ? (ZERO - s_pulse_mag) : (ZERO + s_pulse_mag);
    end

    always_ff @(posedge i_clk) begin
        o_power <= n_power;
        o_pulse <= n_pulse;
    end

endmodule
`default_nettype wire

FILE: hdl/two_axis_position_servo_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_axis_position_servo_unit: two-axis proportional position servo
// Clamps targets to their windows, applies a dead band, gain, friction
// offset and power limits per axis, and produces drive power and pulses.
// ---------------------------------------------------------------------------
// o_done strobes once a beat has left the input register and the three axis stages.
// Throughput: one beat per cycle; o_busy is high only while reset is held,
// the four-stage pipeline (input register plus three axis stages) accepts every cycle.
// Reset: synchronous active-low reset loads the register reset values
// and clears the pipeline valid bits; results cannot be stalled.
// ---------------------------------------------------------------------------
module two_axis_position_servo_unit #(
    parameter int PULSE_ZERO = 90,
    parameter int PULSE_SPAN = 90
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [10:0] i_left_target,
    input  wire logic signed [10:0] i_right_target,
    input  wire logic signed [10:0] i_left_position,
    input  wire logic signed [10:0] i_right_position,
    input  wire logic               i_left_lower_stop,
    input  wire logic               i_left_upper_stop,
    input  wire logic               i_right_lower_stop,
    input  wire logic               i_right_upper_stop,
    input  wire logic               i_drive_enable,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_done,
    output logic signed [7:0]       o_left_power,
    output logic signed [7:0]       o_right_power,
    output logic [7:0]              o_left_pulse,
    output logic [7:0]              o_right_pulse
);
    import tas_pkg::*;

    // Nothing is taken while reset is held
    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // Configuration registers
    t_axis_cfg r_left_cfg;
    t_axis_cfg r_right_cfg;
    t_loop_cfg r_loop_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cfg.low_bound   <= RST_LOW_BOUND;
            r_left_cfg.high_bound  <= RST_HIGH_BOUND;
            r_left_cfg.friction    <= RST_FRICTION[7:0];
            r_right_cfg.low_bound  <= RST_LOW_BOUND;
            r_right_cfg.high_bound <= RST_HIGH_BOUND;
            r_right_cfg.friction   <= RST_FRICTION[15:8];
            r_loop_cfg.null_band   <= RST_NULL_BAND;
            r_loop_cfg.gain        <= RST_GAIN;
            r_loop_cfg.power_cap   <= RST_POWER_CAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEFT_LOW:   r_left_cfg.low_bound   <= i_cfg_data[10:0];
                CFG_LEFT_HIGH:  r_left_cfg.high_bound  <= i_cfg_data[10:0];
                CFG_RIGHT_LOW:  r_right_cfg.low_bound  <= i_cfg_data[10:0];
                CFG_RIGHT_HIGH: r_right_cfg.high_bound <= i_cfg_data[10:0];
                CFG_NULL_BAND:  r_loop_cfg.null_band   <= i_cfg_data[7:0];
                CFG_GAIN:       r_loop_cfg.gain        <= i_cfg_data[7:0];
                CFG_FRICTION: begin
                    r_left_cfg.friction  <= i_cfg_data[7:0];
                    r_right_cfg.friction <= i_cfg_data[15:8];
                end
                CFG_POWER_CAP:  r_loop_cfg.power_cap   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Valid bits: input register, then three axis stages
    logic [3:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'b0000;
        end else begin
            r_vld <= {r_vld[2:0], i_start && !o_busy};
        end
    end

    assign o_done = r_vld[3];

    // Input register for the accepted beat
    logic signed [10:0] r_left_target;
    logic signed [10:0] r_right_target;
    logic signed [10:0] r_left_position;
    logic signed [10:0] r_right_position;
    t_axis_ctl          r_left_ctl;
    t_axis_ctl          r_right_ctl;

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_left_target        <= i_left_target;
            r_right_target       <= i_right_target;
            r_left_position      <= i_left_position;
            r_right_position     <= i_right_position;
            r_left_ctl.enable    <= i_drive_enable;
            r_left_ctl.low_stop  <= i_left_lower_stop;
            r_left_ctl.high_stop <= i_left_upper_stop;
            r_right_ctl.enable    <= i_drive_enable;
            r_right_ctl.low_stop  <= i_right_lower_stop;
            r_right_ctl.high_stop <= i_right_upper_stop;
        end
    end

    // Axis datapaths
    tas_axis #(
        .PULSE_ZERO (PULSE_ZERO),
        .PULSE_SPAN (PULSE_SPAN)
    ) u_left_axis (
        .i_clk      (i_clk),
        .i_axis_cfg (r_left_cfg),
        .i_loop_cfg (r_loop_cfg),
        .i_ctl      (r_left_ctl),
        .i_target   (r_left_target),
        .i_position (r_left_position),
        .o_power    (o_left_power),
        .o_pulse    (o_left_pulse)
    );

    tas_axis #(
        .PULSE_ZERO (PULSE_ZERO),
        .PULSE_SPAN (PULSE_SPAN)
    ) u_right_axis (
        .i_clk      (i_clk),
        .i_axis_cfg (r_right_cfg),
        .i_loop_cfg (r_loop_cfg),
        .i_ctl      (r_right_ctl),
        .i_target   (r_right_target),
        .i_position (r_right_position),
        .o_power    (o_right_power),
        .o_pulse    (o_right_pulse)
    );

endmodule
`default_nettype wire

FILE: bench/servo_drive_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// servo_drive_checker: result predictor and scoreboard for the servo unit
// Follows configuration writes and accepted control ticks, computes the
// drive power and servo pulse of both axes for every tick, and compares
// each strobed result with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module servo_drive_checker #(
    parameter int PULSE_ZERO = 90,
    parameter int PULSE_SPAN = 90
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic signed [10:0] i_left_target,
    input  wire logic signed [10:0] i_right_target,
    input  wire logic signed [10:0] i_left_position,
    input  wire logic signed [10:0] i_right_position,
    input  wire logic               i_left_lower_stop,
    input  wire logic               i_left_upper_stop,
    input  wire logic               i_right_lower_stop,
    input  wire logic               i_right_upper_stop,
    input  wire logic               i_drive_enable,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_done,
    input  wire logic signed [7:0]  i_left_power,
    input  wire logic signed [7:0]  i_right_power,
    input  wire logic [7:0]         i_left_pulse,
    input  wire logic [7:0]         i_right_pulse,
    output int                      o_fail_count,
    output int                      o_pending
);
    import tas_pkg::*;

    // One predicted result beat.
    typedef struct packed {
        logic signed [7:0] left_power;
        logic signed [7:0] right_power;
        logic [7:0]        left_pulse;
        logic [7:0]        right_pulse;
    } drive_result_t;

    // Shadow copy of the register file.
    int          left_low;
    int          left_high;
    int          right_low;
    int          right_high;
    int          null_band;
    int          gain;
    int          power_limit;
    logic [15:0] friction;

    drive_result_t expected_drive[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Clamps a value to the symmetric range -lim..lim.
    function automatic int limit_magnitude(int v, int lim);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    // Drive percent of one axis for the current register settings.
    function automatic int axis_drive_percent(int target, int pos, int lo, int hi, int fric,
                                              logic en, logic low_stop, logic high_stop);
        int aim;
        int err;
        int mag;
        int pwr;
        aim = target;
        if (aim > hi) aim = hi;
        if (aim < lo) aim = lo;
        err = aim - pos;
        mag = (err < 0) ? -err : err;
        pwr = 0;
        if (en && mag > null_band) begin
            pwr = (err * gain) / 10;
            // Static friction is added away from zero, never to a zero term.
            if (pwr > 0) pwr = pwr + fric;
            else if (pwr < 0) pwr = pwr - fric;
            pwr = limit_magnitude(pwr, 100);
        end
        pwr = limit_magnitude(pwr, power_limit);
        if (high_stop && pwr > 0) pwr = 0;
        if (low_stop && pwr < 0) pwr = 0;
        return pwr;
    endfunction

    // Servo command for a drive percent; only the low byte is kept.
    function automatic logic [7:0] servo_pulse(int pwr);
        return 8'((pwr * PULSE_SPAN) / 100 + PULSE_ZERO);
    endfunction

    function automatic drive_result_t predict_drive();
        drive_result_t r;
        int lp;
        int rp;
        lp = axis_drive_percent(int'(i_left_target), int'(i_left_position), left_low, left_high,
                                int'(friction[7:0]), i_drive_enable,
                                i_left_lower_stop, i_left_upper_stop);
        rp = axis_drive_percent(int'(i_right_target), int'(i_right_position), right_low,
                                right_high, int'(friction[15:8]), i_drive_enable,
                                i_right_lower_stop, i_right_upper_stop);
        r.left_power  = 8'(lp);
        r.right_power = 8'(rp);
        r.left_pulse  = servo_pulse(lp);
        r.right_pulse = servo_pulse(rp);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got, input bit as_signed);
        if (got !== want) begin
            if (as_signed)
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            else
                $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    // Register shadow, prediction on accepted ticks, and result comparison.
    always @(posedge i_clk) begin
        drive_result_t want;
        if (!i_rst_n) begin
            left_low    = int'(RST_LOW_BOUND);
            left_high   = int'(RST_HIGH_BOUND);
            right_low   = int'(RST_LOW_BOUND);
            right_high  = int'(RST_HIGH_BOUND);
            null_band   = int'(RST_NULL_BAND);
            gain        = int'(RST_GAIN);
            friction    = RST_FRICTION;
            power_limit = int'(RST_POWER_CAP);
            expected_drive.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEFT_LOW:   left_low    = int'(signed'(i_cfg_data[10:0]));
                    CFG_LEFT_HIGH:  left_high   = int'(signed'(i_cfg_data[10:0]));
                    CFG_RIGHT_LOW:  right_low   = int'(signed'(i_cfg_data[10:0]));
                    CFG_RIGHT_HIGH: right_high  = int'(signed'(i_cfg_data[10:0]));
                    CFG_NULL_BAND:  null_band   = int'(i_cfg_data[7:0]);
                    CFG_GAIN:       gain        = int'(i_cfg_data[7:0]);
                    CFG_FRICTION:   friction    = i_cfg_data;
                    CFG_POWER_CAP:  power_limit = int'(i_cfg_data[6:0]);
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                expected_drive.push_back(predict_drive());
            if (i_done) begin
                if (expected_drive.size() == 0) begin
                    $error("result beat arrived with no tick outstanding");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_drive.pop_front();
                    compare_field("left_power", want.left_power, i_left_power, 1'b1);
                    compare_field("right_power", want.right_power, i_right_power, 1'b1);
                    compare_field("left_pulse", want.left_pulse, i_left_pulse, 1'b0);
                    compare_field("right_pulse", want.right_pulse, i_right_pulse, 1'b0);
                end
            end
        end
        o_pending = expected_drive.size();
    end

endmodule
`default_nettype wire

FILE: bench/two_axis_position_servo_unit_test.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_axis_position_servo_unit_test: stimulus and verdict for the servo unit
// Drives directed control ticks over the limits, dead band, friction and
// stop switch cases, then random ticks under a series of register setups
// with random idle bursts in most runs. Results are checked by servo_drive_checker.
// ---------------------------------------------------------------------------
module two_axis_position_servo_unit_test;
    import tas_pkg::*;

    localparam int PULSE_ZERO = 90;
    localparam int PULSE_SPAN = 90;

    // One control tick as driven on the input ports.
    typedef struct packed {
        logic signed [10:0] left_target;
        logic signed [10:0] right_target;
        logic signed [10:0] left_position;
        logic signed [10:0] right_position;
        logic [3:0]         stops;          // right upper, right lower, left upper, left lower
        logic               drive_enable;
    } servo_tick_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [10:0] i_left_target;
    logic signed [10:0] i_right_target;
    logic signed [10:0] i_left_position;
    logic signed [10:0] i_right_position;
    logic               i_left_lower_stop;
    logic               i_left_upper_stop;
    logic               i_right_lower_stop;
    logic               i_right_upper_stop;
    logic               i_drive_enable;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               o_done;
    logic signed [7:0]  o_left_power;
    logic signed [7:0]  o_right_power;
    logic [7:0]         o_left_pulse;
    logic [7:0]         o_right_pulse;

    logic beat_taken;
    logic cfg_taken;
    int   fail_count;
    int   ticks_outstanding;

    two_axis_position_servo_unit #(
        .PULSE_ZERO(PULSE_ZERO),
        .PULSE_SPAN(PULSE_SPAN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .o_busy             (o_busy),
        .i_left_target      (i_left_target),
        .i_right_target     (i_right_target),
        .i_left_position    (i_left_position),
        .i_right_position   (i_right_position),
        .i_left_lower_stop  (i_left_lower_stop),
        .i_left_upper_stop  (i_left_upper_stop),
        .i_right_lower_stop (i_right_lower_stop),
        .i_right_upper_stop (i_right_upper_stop),
        .i_drive_enable     (i_drive_enable),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_left_power       (o_left_power),
        .o_right_power      (o_right_power),
        .o_left_pulse       (o_left_pulse),
        .o_right_pulse      (o_right_pulse)
    );

    servo_drive_checker #(
        .PULSE_ZERO(PULSE_ZERO),
        .PULSE_SPAN(PULSE_SPAN)
    ) checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .i_busy             (o_busy),
        .i_left_target      (i_left_target),
        .i_right_target     (i_right_target),
        .i_left_position    (i_left_position),
        .i_right_position   (i_right_position),
        .i_left_lower_stop  (i_left_lower_stop),
        .i_left_upper_stop  (i_left_upper_stop),
        .i_right_lower_stop (i_right_lower_stop),
        .i_right_upper_stop (i_right_upper_stop),
        .i_drive_enable     (i_drive_enable),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_done             (o_done),
        .i_left_power       (o_left_power),
        .i_right_power      (o_right_power),
        .i_left_pulse       (o_left_pulse),
        .i_right_pulse      (o_right_pulse),
        .o_fail_count       (fail_count),
        .o_pending          (ticks_outstanding)
    );

    // Clock with a period of 4 time units.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Handshake flags registered at the rising edge, read at the falling edge.
    always @(posedge i_clk) begin
        beat_taken <= i_start && !o_busy;
        cfg_taken  <= i_cfg_valid && o_cfg_ready;
    end

    // Watchdog for a hung handshake or missing results.
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic servo_tick_t make_tick(int lt, int rt, int lp, int rp,
                                              logic [3:0] stops, logic en);
        servo_tick_t t;
        t.left_target    = 11'(lt);
        t.right_target   = 11'(rt);
        t.left_position  = 11'(lp);
        t.right_position = 11'(rp);
        t.stops          = stops;
        t.drive_enable   = en;
        return t;
    endfunction

    // Position counts, biased toward the default travel window.
    function automatic logic signed [10:0] random_counts();
        int v;
        if ($urandom_range(0, 1) == 1)
            v = int'($urandom_range(0, 900)) - 450;
        else
            v = int'($urandom_range(0, 2046)) - 1023;
        return 11'(v);
    endfunction

    // Measured position, often close to the target so the dead band matters.
    function automatic logic signed [10:0] nearby_counts(logic signed [10:0] aim);
        int v;
        if ($urandom_range(0, 1) == 1)
            return random_counts();
        v = int'(aim) + int'($urandom_range(0, 80)) - 40;
        if (v > 1023) v = 1023;
        if (v < -1023) v = -1023;
        return 11'(v);
    endfunction

    function automatic servo_tick_t random_tick();
        servo_tick_t t;
        t.left_target    = random_counts();
        t.right_target   = random_counts();
        t.left_position  = nearby_counts(t.left_target);
        t.right_position = nearby_counts(t.right_target);
        for (int k = 0; k < 4; k++)
            t.stops[k] = ($urandom_range(0, 3) == 0);
        t.drive_enable = ($urandom_range(0, 7) != 0);
        return t;
    endfunction

    // Presents one tick and holds it until the beat is taken.
    task automatic drive_tick(input servo_tick_t t);
        i_left_target      <= t.left_target;
        i_right_target     <= t.right_target;
        i_left_position    <= t.left_position;
        i_right_position   <= t.right_position;
        i_left_lower_stop  <= t.stops[0];
        i_left_upper_stop  <= t.stops[1];
        i_right_lower_stop <= t.stops[2];
        i_right_upper_stop <= t.stops[3];
        i_drive_enable     <= t.drive_enable;
        i_start            <= 1'b1;
        do @(negedge i_clk); while (!beat_taken);
    endtask

    task automatic hold_off(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stops issuing ticks and waits until every result has come back.
    task automatic wait_drained();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (ticks_outstanding != 0) @(negedge i_clk);
    endtask

    // Leaves valid high so that back-to-back writes need no lowering.
    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_taken);
    endtask

    // Writes the whole register file; unused upper data bits carry noise.
    task automatic write_setup(input int ll, input int lh, input int rl, input int rh,
                               input int db, input int g, input logic [15:0] fric,
                               input int lim);
        wait_drained();
        cfg_write(CFG_LEFT_LOW, {5'($urandom), 11'(ll)});
        cfg_write(CFG_LEFT_HIGH, {5'($urandom), 11'(lh)});
        cfg_write(CFG_RIGHT_LOW, {5'($urandom), 11'(rl)});
        cfg_write(CFG_RIGHT_HIGH, {5'($urandom), 11'(rh)});
        cfg_write(CFG_NULL_BAND, {8'($urandom), 8'(db)});
        cfg_write(CFG_GAIN, {8'($urandom), 8'(g)});
        cfg_write(CFG_FRICTION, fric);
        cfg_write(CFG_POWER_CAP, {9'($urandom), 7'(lim)});
        i_cfg_valid <= 1'b0;
    endtask

    // Travel window, occasionally inverted.
    task automatic random_window(output int lo, output int hi);
        int a;
        int b;
        a = int'($urandom_range(0, 2046)) - 1023;
        b = int'($urandom_range(0, 2046)) - 1023;
        if ((a > b) == ($urandom_range(0, 5) != 0)) begin
            lo = b;
            hi = a;
        end else begin
            lo = a;
            hi = b;
        end
    endtask

    task automatic write_random_setup();
        int ll, lh, rl, rh, db, lim;
        random_window(ll, lh);
        random_window(rl, rh);
        db  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
        lim = ($urandom_range(0, 4) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
        write_setup(ll, lh, rl, rh, db, $urandom_range(0, 255), 16'($urandom), lim);
    endtask

    // Random ticks; idle bursts come and go in stretches when allowed.
    task automatic run_random(input int count, input bit allow_idle);
        bit idling;
        idling = allow_idle;
        for (int n = 0; n < count; n++) begin
            if (allow_idle && $urandom_range(0, 29) == 0)
                idling = !idling;
            if (idling && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 12));
            drive_tick(random_tick());
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n            <= 1'b0;
        i_start            <= 1'b0;
        i_left_target      <= '0;
        i_right_target     <= '0;
        i_left_position    <= '0;
        i_right_position   <= '0;
        i_left_lower_stop  <= 1'b0;
        i_left_upper_stop  <= 1'b0;
        i_right_lower_stop <= 1'b0;
        i_right_upper_stop <= 1'b0;
        i_drive_enable     <= 1'b0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= CFG_LEFT_LOW;
        i_cfg_data         <= '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: disable, full scale, dead band edges and stop switches.
        drive_tick(make_tick(300, -300, -300, 300, 4'b0000, 1'b0));
        drive_tick(make_tick(1023, -1023, -1023, 1023, 4'b0000, 1'b1));
        drive_tick(make_tick(5, 6, 0, 0, 4'b0000, 1'b1));
        drive_tick(make_tick(-6, -5, 0, 0, 4'b0000, 1'b1));
        drive_tick(make_tick(100, -100, 0, 0, 4'b0110, 1'b1));
        drive_tick(make_tick(100, -100, 0, 0, 4'b1001, 1'b1));
        drive_tick(make_tick(-100, 100, 0, 0, 4'b1111, 1'b1));
        drive_tick(make_tick(-1023, 1023, -1023, 1023, 4'b0000, 1'b1));
        drive_tick(make_tick(0, 0, 0, 0, 4'b0000, 1'b1));
        drive_tick(make_tick(1023, 1023, 1023, 1023, 4'b1111, 1'b1));
        drive_tick(make_tick(-1023, -1023, 1023, 1023, 4'b0000, 1'b0));
        drive_tick(make_tick(37, -250, 20, -300, 4'b0000, 1'b1));
        run_random(100, 1'b1);

        // Low gain with friction: zero proportional term, offsets, cap above full scale.
        write_setup(-1023, 1023, -1023, 1023, 0, 1, 16'h0A14, 127);
        drive_tick(make_tick(9, -9, 0, 0, 4'b0000, 1'b1));
        drive_tick(make_tick(10, -10, 0, 0, 4'b0000, 1'b1));
        drive_tick(make_tick(800, -800, 0, 0, 4'b0000, 1'b1));
        drive_tick(make_tick(1023, -1023, -1023, 1023, 4'b0000, 1'b1));
        drive_tick(make_tick(-800, 800, 0, 0, 4'b0000, 1'b1));
        run_random(100, 1'b1);

        // Dead band, gain, friction and power cap at their top values, windows -1023 to 1023.
        write_setup(-1023, 1023, -1023, 1023, 255, 255, 16'hFFFF, 127);
        run_random(100, 1'b1);

        // Inverted windows: the target always lands on the low bound.
        write_setup(500, -500, 1023, -1023, 0, 255, 16'h0000, 50);
        run_random(100, 1'b1);

        // Zero power cap.
        write_setup(-400, 400, -400, 400, 0, 3, 16'h0505, 0);
        run_random(50, 1'b1);

        // Random setups; the last one runs without idle cycles.
        for (int s = 0; s < 6; s++) begin
            write_random_setup();
            run_random(100, 1'b1);
        end
        write_random_setup();
        run_random(200, 1'b0);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && ticks_outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
hdl/tas_pkg.sv
hdl/tas_axis.sv
hdl/two_axis_position_servo_unit.sv
bench/servo_drive_checker.sv
bench/two_axis_position_servo_unit_test.sv
